// ----- hdl/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// shared widths and defaults of the streaming top-k sum selector
// ----------------------------------------------------------------------------
package tks_pkg;
	localparam int SAMPLE_W     = 32;
	localparam int SUM_W        = 40;
	localparam int LIMIT_W      = 7;
	localparam int DEF_CAPACITY = 64;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);
endpackage

// ----- hdl/tks_ram.sv -----
// ----------------------------------------------------------------------------
// tks_ram
// value store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tks_ram
	import tks_pkg::*;
#(
	parameter int DEPTH = DEF_CAPACITY,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);
	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/top_k_sum_selector_top.sv -----
// ----------------------------------------------------------------------------
// top_k_sum_selector_top
// keeps the k largest values of a set in ascending order and sums them
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// config   | keep_count_limit_we        | keep_count_limit
// input    | in_valid / in_ready        | sample_value, last_of_set
// output   | out_valid / out_ready      | top_sum
//
// one request at a time: a new item is taken only when the last is done;
// each stored value moved on insert or min replacement takes a store read and a
// compare in turn, set by the single read port of the value store.
// reset clears count, sum and result; the store itself is never cleared.
// a finished result waits in an output register; a last item stalls only
// while the previous result is still untaken.
// ----------------------------------------------------------------------------
module top_k_sum_selector_top
	import tks_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       keep_count_limit_we,
	input  logic [LIMIT_W-1:0]         keep_count_limit,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       last_of_set,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SUM_W-1:0]    top_sum
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_INS_RD, ST_INS_CMP, ST_INS_PUT,
		ST_REP_CMP0, ST_REP_RD, ST_REP_CMP, ST_REP_PUT, ST_DONE
	} state_t;

	state_t                     state_q;
	logic [LIMIT_W-1:0]         limit_q;
	logic [CW-1:0]              held_q;
	logic [CW-1:0]              idx_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic                       last_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       out_valid_q;
	logic signed [SUM_W-1:0]    top_sum_q;

	logic [CW-1:0]              eff_k;
	logic                       add_mode, rep_mode, out_free, emit;
	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [SAMPLE_W-1:0]        wdata, rdata;
	logic signed [SAMPLE_W-1:0] rd_s;
	logic signed [SUM_W-1:0]    v_ext, rd_ext;

	assign eff_k    = (int'(limit_q) > CAPACITY) ? CW'(CAPACITY) : CW'(limit_q);
	assign add_mode = held_q < eff_k;
	assign rep_mode = (held_q != '0) && (eff_k != '0);
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == ST_DONE) && last_q && out_free;
	assign rd_s     = $signed(rdata);
	assign v_ext    = SUM_W'(v_q);
	assign rd_ext   = SUM_W'(rd_s);

	// store port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = v_q;
		re    = 1'b0;
		raddr = '0;
		unique case (state_q)
			ST_DECIDE: begin
				if (add_mode) begin
					if (held_q == '0) begin
						we    = 1'b1;
						waddr = '0;
					end
				end else if (rep_mode) begin
					re = 1'b1;
				end
			end
			ST_INS_RD: begin
				re    = 1'b1;
				raddr = AW'(idx_q - CW'(1));
			end
			ST_INS_CMP: begin
				we = 1'b1;
				if (rd_s > v_q) begin
					wdata = rdata;
				end
			end
			ST_INS_PUT, ST_REP_PUT: begin
				we = 1'b1;
			end
			ST_REP_CMP0: begin
				if (v_q > rd_s && held_q == CW'(1)) begin
					we    = 1'b1;
					waddr = '0;
				end
			end
			ST_REP_RD: begin
				re    = 1'b1;
				raddr = AW'(idx_q + CW'(1));
			end
			ST_REP_CMP: begin
				we = 1'b1;
				if (rd_s < v_q) begin
					wdata = rdata;
				end
			end
			default: begin
			end
		endcase
	end

	tks_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RESET;
			held_q      <= '0;
			idx_q       <= '0;
			v_q         <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			top_sum_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (keep_count_limit_we) begin
				limit_q <= keep_count_limit;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q     <= sample_value;
						last_q  <= last_of_set;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (add_mode) begin
						held_q <= held_q + CW'(1);
						sum_q  <= sum_q + v_ext;
						idx_q  <= held_q;
						state_q <= (held_q == '0) ? ST_DONE : ST_INS_RD;
					end else if (rep_mode) begin
						state_q <= ST_REP_CMP0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					if (rd_s > v_q) begin
						idx_q   <= idx_q - CW'(1);
						state_q <= (idx_q == CW'(1)) ? ST_INS_PUT : ST_INS_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_REP_CMP0: begin
					idx_q <= '0;
					if (v_q > rd_s) begin
						sum_q   <= sum_q + v_ext - rd_ext;
						state_q <= (held_q > CW'(1)) ? ST_REP_RD : ST_DONE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_REP_RD: begin
					state_q <= ST_REP_CMP;
				end
				ST_REP_CMP: begin
					if (rd_s < v_q) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ((idx_q + CW'(2)) < held_q) ? ST_REP_RD : ST_REP_PUT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_INS_PUT, ST_REP_PUT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						top_sum_q   <= sum_q;
						sum_q       <= '0;
						held_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign top_sum   = top_sum_q;

`ifndef SYNTH
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(held_q) <= CAPACITY)
		else $error("held count above capacity");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && last_q && out_free |=> held_q == '0 && sum_q == '0
			&& out_valid_q)
		else $error("store not cleared after last request");

	a_result_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q && out_valid_q != $past(out_valid_q) |-> $past(out_ready))
		else $error("result dropped without being taken");
`endif
endmodule

// ----- test/top_k_sum_selector_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_sum_selector_checker
// watches the config, input and output channels of the top-k sum selector,
// keeps its own sorted store of the k largest values, predicts each set sum
// and compares every accepted result against the oldest prediction
// ----------------------------------------------------------------------------
module top_k_sum_selector_checker
	import tks_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       keep_count_limit_we,
	input  logic [LIMIT_W-1:0]         keep_count_limit,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic                       last_of_set,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [SUM_W-1:0]    top_sum,
	output int                         fail_count,
	output int                         sums_pending
);
	logic signed [SAMPLE_W-1:0] kept [CAPACITY];
	int unsigned                kept_n;
	logic [LIMIT_W-1:0]         k_reg;
	logic signed [SUM_W-1:0]    sum_queue [$];

	function automatic int unsigned eff_k();
		return (k_reg > CAPACITY) ? CAPACITY : k_reg;
	endfunction

	task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] v, input logic last);
		int unsigned pos;
		int unsigned k;
		logic signed [SUM_W-1:0] acc;
		k = eff_k();
		if (kept_n < k) begin
			pos = kept_n;
			while (pos > 0 && kept[pos-1] > v) begin
				kept[pos] = kept[pos-1];
				pos--;
			end
			kept[pos] = v;
			kept_n++;
		end else if (kept_n > 0 && k > 0 && v > kept[0]) begin
			pos = 0;
			while (pos + 1 < kept_n && kept[pos+1] < v) begin
				kept[pos] = kept[pos+1];
				pos++;
			end
			kept[pos] = v;
		end
		if (last) begin
			acc = '0;
			for (int i = 0; i < kept_n; i++)
				acc += SUM_W'(kept[i]);
			kept_n = 0;
			sum_queue.push_back(acc);
		end
	endtask

	assign sums_pending = sum_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_n = 0;
			k_reg = LIMIT_RESET;
			fail_count = 0;
			sum_queue.delete();
		end else begin
			if (keep_count_limit_we)
				k_reg = keep_count_limit;
			if (in_valid && in_ready)
				absorb_sample(sample_value, last_of_set);
			if (out_valid && out_ready) begin
				if (sum_queue.size() == 0) begin
					$error("top_sum: unexpected result %0d", top_sum);
					fail_count++;
				end else begin
					if (top_sum !== sum_queue[0]) begin
						$error("top_sum: expected %0d actual %0d", sum_queue[0], top_sum);
						fail_count++;
					end
					void'(sum_queue.pop_front());
				end
			end
		end
	end
endmodule

// ----- test/top_k_sum_selector_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_sum_selector_top_tb
// drives sets of signed samples through the top-k sum selector under several
// k settings, with random gaps, a long receiver hold-off and a drain pause;
// the checker predicts and compares, this module only gives the verdict
// ----------------------------------------------------------------------------
module top_k_sum_selector_top_tb;
	import tks_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;

	logic                       clk;
	logic                       arst_n;
	logic                       keep_count_limit_we;
	logic [LIMIT_W-1:0]         keep_count_limit;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last_of_set;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SUM_W-1:0]    top_sum;
	int                         fail_count;
	int                         sums_pending;
	int                         cycles;
	int                         samples_sent;
	int                         hold_off;
	bit                         calm;

	top_k_sum_selector_top uut (
		.clk(clk), .arst_n(arst_n),
		.keep_count_limit_we(keep_count_limit_we), .keep_count_limit(keep_count_limit),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_value(sample_value), .last_of_set(last_of_set),
		.out_valid(out_valid), .out_ready(out_ready), .top_sum(top_sum)
	);

	top_k_sum_selector_checker chk (
		.clk(clk), .arst_n(arst_n),
		.keep_count_limit_we(keep_count_limit_we), .keep_count_limit(keep_count_limit),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_value(sample_value), .last_of_set(last_of_set),
		.out_valid(out_valid), .out_ready(out_ready), .top_sum(top_sum),
		.fail_count(fail_count), .sums_pending(sums_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver with random stalls and an optional long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				out_ready = 1'b0;
			end else if (calm)
				out_ready = 1'b1;
			else
				out_ready = ($urandom_range(0, 99) >= 33);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3: return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic last);
		bit taken;
		if (!calm && $urandom_range(0, 99) < 33) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		sample_value = v;
		last_of_set = last;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = in_ready;
		end
		samples_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_set(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_sample(pick_value(), close && (i == len - 1));
	endtask

	task automatic wait_drain();
		wait (sums_pending == 0);
		repeat (2 * DEF_CAPACITY + 20) @(negedge clk);
	endtask

	task automatic write_k(input int k);
		wait_drain();
		keep_count_limit_we = 1'b1;
		keep_count_limit = LIMIT_W'(k);
		@(negedge clk);
		keep_count_limit_we = 1'b0;
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		keep_count_limit_we = 1'b0;
		keep_count_limit = '0;
		in_valid = 1'b0;
		sample_value = '0;
		last_of_set = 1'b0;
		hold_off = 0;
		calm = 0;
		cycles = 0;
		samples_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default k of one, extremes
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh7fff_ffff, 1'b1);
		send_sample(-5, 1'b0);
		send_sample(-5, 1'b0);
		send_sample(-7, 1'b1);
		// k of zero gives a zero sum
		write_k(0);
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(3, 1'b1);
		// full store of max values
		write_k(DEF_CAPACITY);
		for (int i = 0; i < DEF_CAPACITY + 2; i++)
			send_sample(32'sh7fff_ffff, i == DEF_CAPACITY + 1);
		// k above capacity saturates
		write_k(127);
		send_set(DEF_CAPACITY + 4, 1);
		// k lowered mid-set below the held count
		write_k(8);
		for (int i = 0; i < 6; i++)
			send_sample(10 * i - 20, 1'b0);
		write_k(3);
		send_sample(-100, 1'b0);
		send_sample(1000, 1'b0);
		send_sample(0, 1'b1);

		// random phases
		for (int ph = 0; samples_sent < 740; ph++) begin
			case ($urandom_range(0, 9))
				0: k = 0;
				1: k = DEF_CAPACITY;
				2: k = 127;
				3: k = $urandom_range(0, 127);
				default: k = $urandom_range(1, 8);
			endcase
			write_k(k);
			calm = (ph == 3);
			if (ph == 5) begin
				hold_off = 400;
				for (int s = 0; s < 12; s++)
					send_set($urandom_range(1, 3), 1);
			end else begin
				for (int s = $urandom_range(3, 8); s > 0; s--)
					send_set(($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 12), 1);
				if ($urandom_range(0, 3) == 0)
					send_set($urandom_range(1, 10), 0);
			end
			if (ph == 7) begin
				wait (sums_pending == 0);
				@(negedge clk);
			end
			calm = 0;
		end
		send_sample(pick_value(), 1'b1);

		wait (sums_pending == 0);
		repeat (2 * DEF_CAPACITY + 20) @(posedge clk);
		if (fail_count == 0 && sums_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
